// File: hdl/ogi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_pkg
// Shared types, constants and codes for the occupancy grid inflation block.
// ----------------------------------------------------------------------------
package ogi_pkg;

    localparam int GRID_ROWS = 128;
    localparam int GRID_COLS = 128;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int CNT_W     = 8;
    localparam int POS_W     = 11;
    localparam int DIV_W     = 12;
    localparam int DEN_W     = 5;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int NUM_REGS  = 5;
    localparam int PADDR_W   = $clog2(NUM_REGS * 4);
    localparam int PDATA_W   = 32;
    localparam int IDX_W     = PADDR_W - 2;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PIXEL = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [IDX_W-1:0] {
        REG_CELL_PIXELS  = IDX_W'(0),
        REG_IMAGE_WIDTH  = IDX_W'(1),
        REG_IMAGE_HEIGHT = IDX_W'(2),
        REG_INFLATE_ROWS = IDX_W'(3),
        REG_INFLATE_COLS = IDX_W'(4)
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_GEOM,
        S_GEOM_WAIT,
        S_IDLE,
        S_PIX_WAIT,
        S_WIN,
        S_WIN_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [4:0]  cell_pixels;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [3:0]  inflate_rows;
        logic [3:0]  inflate_cols;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       action;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_item;

    typedef struct packed {
        logic             blocked;
        logic [CNT_W-1:0] grid_rows;
        logic [CNT_W-1:0] grid_cols;
    } t_result;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_geom;
        logic geom_save;
        logic pix_set;
        logic clr_step;
        logic win_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    black;
        logic    border;
        logic    div_done;
        logic    pix_in;
        logic    clr_last;
        logic    win_last;
        logic    out_free;
    } t_stat;

endpackage

// File: hdl/ogi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_in_if
// Input item channel: action, position and pixel color.
// ----------------------------------------------------------------------------
interface ogi_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [ogi_pkg::POS_W-1:0] pos_x;
    logic [ogi_pkg::POS_W-1:0] pos_y;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;

    modport source (output valid, action, pos_x, pos_y, red, green, blue, input ready);
    modport sink   (input valid, action, pos_x, pos_y, red, green, blue, output ready);
endinterface

// File: hdl/ogi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_out_if
// Result item channel: final map cell state and inner grid size.
// ----------------------------------------------------------------------------
interface ogi_out_if;
    logic                      valid;
    logic                      ready;
    logic                      blocked;
    logic [ogi_pkg::CNT_W-1:0] grid_rows;
    logic [ogi_pkg::CNT_W-1:0] grid_cols;

    modport source (output valid, blocked, grid_rows, grid_cols, input ready);
    modport sink   (input valid, blocked, grid_rows, grid_cols, output ready);
endinterface

// File: hdl/ogi_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_regs
// APB configuration registers with write strobe.
// ----------------------------------------------------------------------------
module ogi_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ogi_pkg::PADDR_W-1:0]   paddr,
    input  logic [ogi_pkg::PDATA_W-1:0]   pwdata,
    output logic [ogi_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output ogi_pkg::t_cfg                 o_cfg,
    output logic                          o_cfg_wr
);

    ogi_pkg::t_cfg    r_cfg;
    ogi_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready   = 1'b1;
    assign w_idx    = ogi_pkg::t_reg_idx'(paddr[ogi_pkg::PADDR_W-1:2]);
    assign w_wr     = psel && penable && pwrite;
    assign o_cfg    = r_cfg;
    assign o_cfg_wr = w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_pixels  <= 5'd1;
            r_cfg.image_width  <= 12'd128;
            r_cfg.image_height <= 12'd128;
            r_cfg.inflate_rows <= 4'd0;
            r_cfg.inflate_cols <= 4'd0;
        end else if (w_wr) begin
            unique case (w_idx)
                ogi_pkg::REG_CELL_PIXELS:  r_cfg.cell_pixels  <= pwdata[4:0];
                ogi_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[11:0];
                ogi_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[11:0];
                ogi_pkg::REG_INFLATE_ROWS: r_cfg.inflate_rows <= pwdata[3:0];
                ogi_pkg::REG_INFLATE_COLS: r_cfg.inflate_cols <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ogi_pkg::REG_CELL_PIXELS:  prdata = ogi_pkg::PDATA_W'(r_cfg.cell_pixels);
            ogi_pkg::REG_IMAGE_WIDTH:  prdata = ogi_pkg::PDATA_W'(r_cfg.image_width);
            ogi_pkg::REG_IMAGE_HEIGHT: prdata = ogi_pkg::PDATA_W'(r_cfg.image_height);
            ogi_pkg::REG_INFLATE_ROWS: prdata = ogi_pkg::PDATA_W'(r_cfg.inflate_rows);
            ogi_pkg::REG_INFLATE_COLS: prdata = ogi_pkg::PDATA_W'(r_cfg.inflate_cols);
            default:                   prdata = '0;
        endcase
    end

endmodule

// File: hdl/ogi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_div
// Two-lane restoring divider by a shared divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ogi_pkg::DIV_W-1:0]   i_num0,
    input  logic [ogi_pkg::DIV_W-1:0]   i_num1,
    input  logic [ogi_pkg::DEN_W-1:0]   i_den,
    output logic [ogi_pkg::DIV_W-1:0]   o_quot0,
    output logic [ogi_pkg::DIV_W-1:0]   o_quot1,
    output logic                        o_done
);

    logic [ogi_pkg::DIV_W-1:0]  r_num [2];
    logic [ogi_pkg::DEN_W-1:0]  r_rem [2];
    logic [ogi_pkg::DIV_W-1:0]  n_num [2];
    logic [ogi_pkg::DEN_W-1:0]  n_rem [2];
    logic [ogi_pkg::DEN_W-1:0]  r_den;
    logic [ogi_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [ogi_pkg::DEN_W:0]    w_trial [2];
    logic                       w_ge [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_trial[k] = {r_rem[k], r_num[k][ogi_pkg::DIV_W-1]};
            w_ge[k]    = w_trial[k] >= {1'b0, r_den};
            n_rem[k]   = w_ge[k] ? ogi_pkg::DEN_W'(w_trial[k] - {1'b0, r_den})
                                 : w_trial[k][ogi_pkg::DEN_W-1:0];
            n_num[k]   = {r_num[k][ogi_pkg::DIV_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num[0] <= i_num0;
            r_num[1] <= i_num1;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
            r_den    <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ogi_pkg::STEP_W'(ogi_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot0 = r_num[0];
    assign o_quot1 = r_num[1];
    assign o_done  = r_done;

endmodule

// File: hdl/ogi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_dp
// Datapath: cell bitmap memory, geometry, window bounds and result register.
// ----------------------------------------------------------------------------
module ogi_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ogi_pkg::t_cfg    i_cfg,
    input  ogi_pkg::t_item   i_item,
    input  ogi_pkg::t_cmd    i_cmd,
    output ogi_pkg::t_stat   o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output ogi_pkg::t_result o_out
);

    localparam int RW = ogi_pkg::ROW_W;
    localparam int CW = ogi_pkg::COL_W;
    localparam int NW = ogi_pkg::CNT_W;
    localparam int PW = ogi_pkg::POS_W;
    localparam int DW = ogi_pkg::DIV_W;

    logic [ogi_pkg::GRID_COLS-1:0] r_mem [ogi_pkg::GRID_ROWS];
    logic [ogi_pkg::GRID_COLS-1:0] r_rdata;
    logic [ogi_pkg::GRID_COLS-1:0] w_mask;
    logic                          r_rd_vld;

    logic [NW-1:0] r_rows;
    logic [NW-1:0] r_cols;
    logic [RW-1:0] r_clr_ctr;
    logic [RW-1:0] r_row_ctr;
    logic [RW-1:0] r_rhi;
    logic [CW-1:0] r_clo;
    logic [CW-1:0] r_chi;
    logic          r_border;
    logic          r_hit;

    logic             r_out_vld;
    ogi_pkg::t_result r_out;

    logic [ogi_pkg::DEN_W-1:0] w_cell;
    logic [DW-1:0]             w_num0;
    logic [DW-1:0]             w_num1;
    logic [DW-1:0]             w_q0;
    logic [DW-1:0]             w_q1;
    logic                      w_div_done;

    logic [NW:0]   w_rows_p1;
    logic [NW:0]   w_cols_p1;
    logic          w_border;
    logic [RW-1:0] w_r;
    logic [CW-1:0] w_c;
    logic [RW-1:0] w_ir;
    logic [CW-1:0] w_ic;
    logic [RW-1:0] w_rlo;
    logic [CW-1:0] w_clo;
    logic [NW-1:0] w_rsum;
    logic [NW-1:0] w_csum;
    logic [NW-1:0] w_rows_m1;
    logic [NW-1:0] w_cols_m1;
    logic [RW-1:0] w_rhi;
    logic [CW-1:0] w_chi;
    logic [RW-1:0] w_wr_row;

    // divider operands
    assign w_cell = (i_cfg.cell_pixels == '0) ? ogi_pkg::DEN_W'(1) : i_cfg.cell_pixels;
    assign w_num0 = i_cmd.div_geom ? i_cfg.image_height : DW'(i_item.pos_y);
    assign w_num1 = i_cmd.div_geom ? i_cfg.image_width  : DW'(i_item.pos_x);

    ogi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num0  (w_num0),
        .i_num1  (w_num1),
        .i_den   (w_cell),
        .o_quot0 (w_q0),
        .o_quot1 (w_q1),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.geom_save) begin
            r_rows <= (w_q0 > DW'(ogi_pkg::GRID_ROWS)) ? NW'(ogi_pkg::GRID_ROWS) : w_q0[NW-1:0];
            r_cols <= (w_q1 > DW'(ogi_pkg::GRID_COLS)) ? NW'(ogi_pkg::GRID_COLS) : w_q1[NW-1:0];
        end
    end

    // read window bounds
    assign w_rows_p1 = {1'b0, r_rows} + (NW+1)'(1);
    assign w_cols_p1 = {1'b0, r_cols} + (NW+1)'(1);
    assign w_border  = (i_item.pos_y == '0) || (i_item.pos_y >= PW'(w_rows_p1))
                    || (i_item.pos_x == '0) || (i_item.pos_x >= PW'(w_cols_p1));
    assign w_r       = RW'(i_item.pos_y - PW'(1));
    assign w_c       = CW'(i_item.pos_x - PW'(1));
    assign w_ir      = RW'(i_cfg.inflate_rows);
    assign w_ic      = CW'(i_cfg.inflate_cols);
    assign w_rlo     = (w_r > w_ir) ? w_r - w_ir : '0;
    assign w_clo     = (w_c > w_ic) ? w_c - w_ic : '0;
    assign w_rsum    = NW'(w_r) + NW'(w_ir);
    assign w_csum    = NW'(w_c) + NW'(w_ic);
    assign w_rows_m1 = r_rows - NW'(1);
    assign w_cols_m1 = r_cols - NW'(1);
    assign w_rhi     = RW'((w_rsum > w_rows_m1) ? w_rows_m1 : w_rsum);
    assign w_chi     = CW'((w_csum > w_cols_m1) ? w_cols_m1 : w_csum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_border <= w_border;
            r_rhi    <= w_rhi;
            r_clo    <= w_clo;
            r_chi    <= w_chi;
        end
    end

    always_comb begin
        for (int j = 0; j < ogi_pkg::GRID_COLS; j++) begin
            w_mask[j] = (CW'(j) >= r_clo) && (CW'(j) <= r_chi);
        end
    end

    // cell bitmap
    assign w_wr_row = i_cmd.clr_step ? r_clr_ctr : w_q0[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[w_wr_row] <= '0;
        end else if (i_cmd.pix_set) begin
            r_mem[w_wr_row][w_q1[CW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_step) begin
            r_rdata <= r_mem[r_row_ctr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ctr <= '0;
            r_row_ctr <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.win_step;
            if (i_cmd.clr_step) begin
                r_clr_ctr <= r_clr_ctr + 1'b1;
            end
            if (i_cmd.load) begin
                r_row_ctr <= w_rlo;
            end else if (i_cmd.win_step) begin
                r_row_ctr <= r_row_ctr + 1'b1;
            end
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_rd_vld) begin
                r_hit <= r_hit | (|(r_rdata & w_mask));
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.blocked   <= r_border | r_hit;
            r_out.grid_rows <= r_rows;
            r_out.grid_cols <= r_cols;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign o_stat.act      = ogi_pkg::t_action'(i_item.action);
    assign o_stat.black    = (i_item.red == '0) && (i_item.green == '0) && (i_item.blue == '0);
    assign o_stat.border   = w_border;
    assign o_stat.div_done = w_div_done;
    assign o_stat.pix_in   = (w_q0 < DW'(r_rows)) && (w_q1 < DW'(r_cols));
    assign o_stat.clr_last = (r_clr_ctr == RW'(ogi_pkg::GRID_ROWS - 1));
    assign o_stat.win_last = (r_row_ctr == r_rhi);
    assign o_stat.out_free = !r_out_vld || i_out_ready;

endmodule

// File: hdl/ogi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_ctrl
// Controller: sequences clear, geometry, pixel write and window read.
// ----------------------------------------------------------------------------
module ogi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_cfg_wr,
    input  ogi_pkg::t_stat i_stat,
    output ogi_pkg::t_cmd  o_cmd
);

    ogi_pkg::t_state r_state;
    ogi_pkg::t_state n_state;
    logic            r_dirty;
    logic            n_dirty;
    logic            w_ready;
    logic            w_accept;

    assign w_ready  = (r_state == ogi_pkg::S_IDLE) && !r_dirty && !i_cfg_wr;
    assign w_accept = w_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ogi_pkg::S_CLEAR;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

    always_comb begin
        n_dirty = i_cfg_wr ? 1'b1 : ((r_state == ogi_pkg::S_GEOM) ? 1'b0 : r_dirty);
        n_state = r_state;
        unique case (r_state)
            ogi_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = ogi_pkg::S_IDLE;
            end
            ogi_pkg::S_GEOM: begin
                n_state = ogi_pkg::S_GEOM_WAIT;
            end
            ogi_pkg::S_GEOM_WAIT: begin
                if (i_stat.div_done) n_state = ogi_pkg::S_IDLE;
            end
            ogi_pkg::S_IDLE: begin
                if (r_dirty) begin
                    n_state = ogi_pkg::S_GEOM;
                end else if (w_accept) begin
                    unique case (i_stat.act)
                        ogi_pkg::ACT_CLEAR: n_state = ogi_pkg::S_CLEAR;
                        ogi_pkg::ACT_PIXEL: n_state = i_stat.black ? ogi_pkg::S_PIX_WAIT
                                                                   : ogi_pkg::S_IDLE;
                        ogi_pkg::ACT_READ:  n_state = i_stat.border ? ogi_pkg::S_RESULT
                                                                    : ogi_pkg::S_WIN;
                        default:            n_state = ogi_pkg::S_IDLE;
                    endcase
                end
            end
            ogi_pkg::S_PIX_WAIT: begin
                if (i_stat.div_done) n_state = ogi_pkg::S_IDLE;
            end
            ogi_pkg::S_WIN: begin
                if (i_stat.win_last) n_state = ogi_pkg::S_WIN_WAIT;
            end
            ogi_pkg::S_WIN_WAIT: begin
                n_state = ogi_pkg::S_RESULT;
            end
            ogi_pkg::S_RESULT: begin
                if (i_stat.out_free) n_state = ogi_pkg::S_IDLE;
            end
            default: n_state = ogi_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = w_ready;
        o_cmd.load      = w_accept;
        o_cmd.div_geom  = (r_state == ogi_pkg::S_GEOM);
        o_cmd.div_start = (r_state == ogi_pkg::S_GEOM)
                       || (w_accept && (i_stat.act == ogi_pkg::ACT_PIXEL) && i_stat.black);
        o_cmd.geom_save = (r_state == ogi_pkg::S_GEOM_WAIT) && i_stat.div_done;
        o_cmd.pix_set   = (r_state == ogi_pkg::S_PIX_WAIT) && i_stat.div_done && i_stat.pix_in;
        o_cmd.clr_step  = (r_state == ogi_pkg::S_CLEAR);
        o_cmd.win_step  = (r_state == ogi_pkg::S_WIN);
        o_cmd.out_load  = (r_state == ogi_pkg::S_RESULT) && i_stat.out_free;
    end

endmodule

// File: hdl/occupancy_grid_inflate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_inflate
// Occupancy grid builder with inflated final map lookup.
// ----------------------------------------------------------------------------
// Input channel i_in carries one item per handshake: clear, pixel write or
// read of a final map cell. Output channel o_out carries one result item per
// read. Registers are to be written over APB only while idle (not enforced).
//
// A clear wipes one bitmap row per cycle. A black pixel write waits for the
// 12-step divider to find its row and column; any other pixel write or unused
// action is taken without a wait state. A read on the map frame goes straight
// to S_RESULT. A read of an inner cell with n window rows (up to 31) reads one
// bitmap row per cycle in S_WIN, then passes S_WIN_WAIT and S_RESULT.
// A register write holds i_in.ready low while the grid is resized.
//
// After reset the block clears the bitmap and resizes the grid before
// i_in.ready rises; register writes are taken throughout.
// The result sits in an output register that a stalled receiver holds; clears
// and pixel writes still go on, but a read holds in its last step, with
// i_in.ready low, until the output register is free.
// ----------------------------------------------------------------------------
module occupancy_grid_inflate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ogi_pkg::PADDR_W-1:0] paddr,
    input  logic [ogi_pkg::PDATA_W-1:0] pwdata,
    output logic [ogi_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    ogi_in_if.sink                      i_in,
    ogi_out_if.source                   o_out
);

    ogi_pkg::t_cfg    w_cfg;
    logic             w_cfg_wr;
    ogi_pkg::t_item   w_item;
    ogi_pkg::t_cmd    w_cmd;
    ogi_pkg::t_stat   w_stat;
    ogi_pkg::t_result w_out;
    logic             w_out_valid;
    logic             w_in_ready;

    assign w_item.action = i_in.action;
    assign w_item.pos_x  = i_in.pos_x;
    assign w_item.pos_y  = i_in.pos_y;
    assign w_item.red    = i_in.red;
    assign w_item.green  = i_in.green;
    assign w_item.blue   = i_in.blue;
    assign i_in.ready    = w_in_ready;

    assign o_out.valid     = w_out_valid;
    assign o_out.blocked   = w_out.blocked;
    assign o_out.grid_rows = w_out.grid_rows;
    assign o_out.grid_cols = w_out.grid_cols;

    ogi_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .o_cfg_wr (w_cfg_wr)
    );

    ogi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_cfg_wr   (w_cfg_wr),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ogi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

endmodule

// File: hdl/ogi_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogi_chk
// Port-level checks for the occupancy grid inflation block.
// ----------------------------------------------------------------------------
module ogi_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic [1:0]                i_in_action,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_blocked,
    input logic [ogi_pkg::CNT_W-1:0] i_out_grid_rows,
    input logic [ogi_pkg::CNT_W-1:0] i_out_grid_cols,
    input logic                      i_psel,
    input logic                      i_penable,
    input logic                      i_pwrite
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable({i_out_blocked, i_out_grid_rows, i_out_grid_cols}))
        else $error("result item changed while stalled");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == 2'(ogi_pkg::ACT_CLEAR)) |=> !i_in_ready)
        else $error("ready during clear sweep");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == 2'(ogi_pkg::ACT_READ)) |=> !i_in_ready)
        else $error("ready during read");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite |=> !i_in_ready)
        else $error("ready before grid size update");

endmodule

bind occupancy_grid_inflate ogi_chk u_ogi_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_action     (i_in.action),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_blocked   (o_out.blocked),
    .i_out_grid_rows (o_out.grid_rows),
    .i_out_grid_cols (o_out.grid_cols),
    .i_psel          (psel),
    .i_penable       (penable),
    .i_pwrite        (pwrite)
);

// File: dv/tb_occupancy_grid_inflate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_inflate
// Self-checking testbench for the occupancy grid inflation block.
// ----------------------------------------------------------------------------
// A predictor keeps its own copy of the cell bitmap and of the registers and
// works out the final map answer for every accepted read. Directed items hit
// the frame, the grid bounds, non-black pixels and the unused action. Random
// phases then run under a range of cell sizes, image sizes and inflation
// radii. Both channels idle and stall at random, and the registers are
// written and read back over APB while the input channel is idle.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_inflate;
    import ogi_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 160;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 180;

    class GridScoreboard;
        bit      cells [GRID_ROWS][GRID_COLS];
        t_cfg    cfg;
        t_result expected_q[$];
        int      mismatches;
        int      items_seen;
        int      reads_checked;
        int      blocked_seen;

        function new();
            cfg = '{cell_pixels: 5'd1, image_width: 12'd128, image_height: 12'd128,
                    inflate_rows: 4'd0, inflate_cols: 4'd0};
            wipe();
            mismatches    = 0;
            items_seen    = 0;
            reads_checked = 0;
            blocked_seen  = 0;
        endfunction

        function void wipe();
            foreach (cells[r, c]) cells[r][c] = 1'b0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_CELL_PIXELS:  cfg.cell_pixels  = value[4:0];
                REG_IMAGE_WIDTH:  cfg.image_width  = value[11:0];
                REG_IMAGE_HEIGHT: cfg.image_height = value[11:0];
                REG_INFLATE_ROWS: cfg.inflate_rows = value[3:0];
                REG_INFLATE_COLS: cfg.inflate_cols = value[3:0];
                default: ;
            endcase
        endfunction

        function int unsigned cell_side();
            return (cfg.cell_pixels == 5'd0) ? 1 : int'(cfg.cell_pixels);
        endfunction

        function int unsigned inner_rows();
            int unsigned n;
            n = int'(cfg.image_height) / cell_side();
            return (n > GRID_ROWS) ? GRID_ROWS : n;
        endfunction

        function int unsigned inner_cols();
            int unsigned n;
            n = int'(cfg.image_width) / cell_side();
            return (n > GRID_COLS) ? GRID_COLS : n;
        endfunction

        function bit map_blocked(int row, int col);
            int rows, cols, ir, ic, rlo, rhi, clo, chi;
            rows = int'(inner_rows());
            cols = int'(inner_cols());
            ir   = int'(cfg.inflate_rows);
            ic   = int'(cfg.inflate_cols);
            if (row > rows + 1 || col > cols + 1) return 1'b1;
            if (row == 0 || row == rows + 1 || col == 0 || col == cols + 1) return 1'b1;
            rlo = (row - 1 - ir < 0) ? 0 : row - 1 - ir;
            rhi = (row - 1 + ir > rows - 1) ? rows - 1 : row - 1 + ir;
            clo = (col - 1 - ic < 0) ? 0 : col - 1 - ic;
            chi = (col - 1 + ic > cols - 1) ? cols - 1 : col - 1 + ic;
            for (int i = rlo; i <= rhi; i++) begin
                for (int j = clo; j <= chi; j++) begin
                    if (cells[i][j]) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_item(t_item it);
            int unsigned r, c;
            t_result     due;
            items_seen++;
            case (t_action'(it.action))
                ACT_CLEAR: wipe();
                ACT_PIXEL: begin
                    r = int'(it.pos_y) / cell_side();
                    c = int'(it.pos_x) / cell_side();
                    if ({it.red, it.green, it.blue} == 24'd0 &&
                            r < inner_rows() && c < inner_cols()) begin
                        cells[r][c] = 1'b1;
                    end
                end
                ACT_READ: begin
                    due.blocked   = map_blocked(int'(it.pos_y), int'(it.pos_x));
                    due.grid_rows = CNT_W'(inner_rows());
                    due.grid_cols = CNT_W'(inner_cols());
                    expected_q.push_back(due);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result due;
            if (expected_q.size() == 0) begin
                $error("result item with none expected: blocked %0d rows %0d cols %0d",
                       got.blocked, got.grid_rows, got.grid_cols);
                mismatches++;
                return;
            end
            due = expected_q.pop_front();
            reads_checked++;
            if (got.blocked === 1'b1) blocked_seen++;
            if (got.blocked !== due.blocked) begin
                $error("blocked: expected %0d, got %0d", due.blocked, got.blocked);
                mismatches++;
            end
            if (got.grid_rows !== due.grid_rows) begin
                $error("grid_rows: expected %0d, got %0d", due.grid_rows, got.grid_rows);
                mismatches++;
            end
            if (got.grid_cols !== due.grid_cols) begin
                $error("grid_cols: expected %0d, got %0d", due.grid_cols, got.grid_cols);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ogi_in_if  in_ch ();
    ogi_out_if out_ch ();

    GridScoreboard sb;
    bit            steady;
    int unsigned   quiet_cycles;

    occupancy_grid_inflate DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (steady || $urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_item('{action: in_ch.action, pos_x: in_ch.pos_x, pos_y: in_ch.pos_y,
                               red: in_ch.red, green: in_ch.green, blue: in_ch.blue});
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result('{blocked: out_ch.blocked, grid_rows: out_ch.grid_rows,
                                  grid_cols: out_ch.grid_cols});
            end
            if (psel && penable && pwrite && pready) begin
                sb.write_reg(t_reg_idx'(paddr[PADDR_W-1:2]), pwdata);
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("occupancy_grid_inflate verification failed");
        $finish;
    end

    function automatic int unsigned clip_pos(int unsigned v);
        return (v > 2047) ? 2047 : v;
    endfunction

    function automatic t_item item_of(t_action act, int unsigned x, int unsigned y,
                                      logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_item it;
        it.action = act;
        it.pos_x  = POS_W'(x);
        it.pos_y  = POS_W'(y);
        it.red    = r;
        it.green  = g;
        it.blue   = b;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        int unsigned pick, sel, cs, rows, cols, x, y;
        pick     = $urandom_range(0, 99);
        cs       = sb.cell_side();
        rows     = sb.inner_rows();
        cols     = sb.inner_cols();
        it.pos_x = POS_W'($urandom);
        it.pos_y = POS_W'($urandom);
        it.red   = 8'($urandom);
        it.green = 8'($urandom);
        it.blue  = 8'($urandom);
        if (pick < 2) begin
            it.action = ACT_CLEAR;
        end else if (pick < 5) begin
            it.action = ACT_NONE;
        end else if (pick < 10) begin
            it.action = $urandom_range(0, 1) ? ACT_PIXEL : ACT_READ;
        end else if (pick < 55) begin
            it.action = ACT_PIXEL;
            if ($urandom_range(0, 99) < 40) {it.red, it.green, it.blue} = 24'd0;
            if ($urandom_range(0, 1)) begin
                x = $urandom_range(0, 13 * cs - 1);
                y = $urandom_range(0, 13 * cs - 1);
            end else begin
                x = $urandom_range(0, int'(sb.cfg.image_width) + cs);
                y = $urandom_range(0, int'(sb.cfg.image_height) + cs);
            end
            it.pos_x = POS_W'(clip_pos(x));
            it.pos_y = POS_W'(clip_pos(y));
        end else begin
            it.action = ACT_READ;
            sel = $urandom_range(0, 9);
            x   = $urandom_range(0, cols + 1);
            y   = $urandom_range(0, rows + 1);
            if (sel < 4) begin
                x = $urandom_range(0, 14);
                y = $urandom_range(0, 14);
            end else if (sel < 9 && sel >= 7) begin
                if ($urandom_range(0, 1)) x = $urandom_range(cols, cols + 3);
                else y = $urandom_range(rows, rows + 3);
            end
            if (sel < 9) begin
                it.pos_x = POS_W'(clip_pos(x));
                it.pos_y = POS_W'(clip_pos(y));
            end
        end
        return it;
    endfunction

    task automatic push_item(input t_item it);
        while (!steady && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.action <= it.action;
        in_ch.pos_x  <= it.pos_x;
        in_ch.pos_y  <= it.pos_y;
        in_ch.red    <= it.red;
        in_ch.green  <= it.green;
        in_ch.blue   <= it.blue;
        in_ch.valid  <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input t_reg_idx idx, input bit wr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_cfg               plan [NUM_PHASES];
        logic [PDATA_W-1:0] wvals [NUM_REGS];
        logic [PDATA_W-1:0] rd;

        sb           = new();
        steady       = 1'b0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_CLEAR;
        in_ch.pos_x  = '0;
        in_ch.pos_y  = '0;
        in_ch.red    = '0;
        in_ch.green  = '0;
        in_ch.blue   = '0;
        out_ch.ready = 1'b0;

        plan[0] = '{5'd4,  12'd512,  12'd300,  4'd2,  4'd1};
        plan[1] = '{5'd0,  12'd2048, 12'd2048, 4'd15, 4'd15};
        plan[2] = '{5'd16, 12'd2048, 12'd1000, 4'd3,  4'd5};
        plan[3] = '{5'd31, 12'd4095, 12'd4095, 4'd1,  4'd0};
        plan[4] = '{5'd2,  12'd0,    12'd60,   4'd4,  4'd4};
        plan[5] = '{5'd1,  12'd1,    12'd1,    4'd0,  4'd15};
        plan[6] = '{5'd3,  12'd100,  12'd4095, 4'd7,  4'd2};
        for (int p = 7; p < NUM_PHASES; p++) begin
            plan[p] = '{5'($urandom), 12'($urandom), 12'($urandom),
                        4'($urandom), 4'($urandom)};
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_item(item_of(ACT_CLEAR, 0, 0, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 0, 0, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 127, 127, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 128, 5, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 5, 128, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 10, 10, 8'd255, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 11, 10, 8'd0, 8'd255, 8'd0));
        push_item(item_of(ACT_PIXEL, 12, 10, 8'd0, 8'd0, 8'd255));
        push_item(item_of(ACT_PIXEL, 2047, 2047, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_NONE, 20, 20, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 1, 1, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 128, 128, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 0, 0, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 129, 129, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 130, 5, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 5, 130, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 2047, 2047, 8'd255, 8'd255, 8'd255));
        push_item(item_of(ACT_READ, 11, 11, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 13, 11, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 21, 21, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_CLEAR, 0, 0, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 1, 1, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_PIXEL, 64, 32, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 65, 33, 8'd0, 8'd0, 8'd0));
        push_item(item_of(ACT_READ, 66, 33, 8'd0, 8'd0, 8'd0));

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            repeat (SETTLE_TICKS) @(negedge i_clk);
            steady   = (p == 1);
            wvals[0] = PDATA_W'(plan[p].cell_pixels);
            wvals[1] = PDATA_W'(plan[p].image_width);
            wvals[2] = PDATA_W'(plan[p].image_height);
            wvals[3] = PDATA_W'(plan[p].inflate_rows);
            wvals[4] = PDATA_W'(plan[p].inflate_cols);
            for (int i = 0; i < NUM_REGS; i++) begin
                apb_access(t_reg_idx'(i), 1'b1, wvals[i], rd);
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                apb_access(t_reg_idx'(i), 1'b0, '0, rd);
                if (rd !== wvals[i]) begin
                    $error("register %0d: expected %0h, got %0h", i, wvals[i], rd);
                    sb.mismatches++;
                end
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) == 0) drain();
                push_item(random_item());
            end
        end

        drain();
        steady = 1'b0;
        repeat (SETTLE_TICKS) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result items never arrived", sb.pending());
            sb.mismatches += sb.pending();
        end
        $display("Ran %0d input items through %0d register settings plus reset values;",
                 sb.items_seen, NUM_PHASES);
        $display("checked %0d read results, %0d of them blocked cells.",
                 sb.reads_checked, sb.blocked_seen);
        if (sb.mismatches == 0) begin
            $display("occupancy_grid_inflate verification clean");
        end else begin
            $display("occupancy_grid_inflate verification failed");
        end
        $finish;
    end

endmodule
